>>> rtl/core/retw_pkg.sv
// ---------------------------------------------------------------------------
// retw_pkg
// Shared types and constants of the retransmit timer wheel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package retw_pkg;

  localparam int CONN_W     = 5;
  localparam int STAMP_W    = 32;
  localparam int TMO_W      = 13;
  localparam int RANK_W     = 48;
  localparam int RESULT_CAP = 32;
  localparam int EMIT_W     = 6;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [CONN_W-1:0]  conn_id;
    logic [STAMP_W-1:0] stamp;
    logic [TMO_W-1:0]   timeout;
    logic [STAMP_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic [CONN_W-1:0] due_conn;
    logic [TMO_W-1:0]  due_timeout;
    logic              last;
  } out_t;

  // classified request between front and back
  typedef struct packed {
    cmd_t               cmd;
    logic [CONN_W-1:0]  conn;
    logic               stamp_zero;
    logic [STAMP_W-1:0] sum;
    logic [TMO_W-1:0]   tmo;
    logic [STAMP_W-1:0] now;
  } req_t;

endpackage
`default_nettype wire

>>> rtl/core/retw_front.sv
// ---------------------------------------------------------------------------
// retw_front
// Accepts requests, drops those that can have no effect, and queues the rest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module retw_front #(
  parameter int MAX_CONNS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire retw_pkg::in_t in_data,
  output logic               q_valid,
  input  wire logic          q_pop,
  output retw_pkg::req_t     q_data
);

  retw_pkg::req_t fifo_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           accept, drop, push, pop;
  retw_pkg::req_t req;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_comb begin
    drop = 1'b0;
    if (in_data.command != retw_pkg::CMD_TICK && int'(in_data.conn_id) >= MAX_CONNS) begin
      drop = 1'b1;
    end
    if (in_data.command == retw_pkg::CMD_REFRESH && in_data.timeout == '0) begin
      drop = 1'b1;
    end
  end

  always_comb begin
    req.cmd        = in_data.command;
    req.conn       = in_data.conn_id;
    req.stamp_zero = (in_data.stamp == '0);
    req.sum        = in_data.stamp + retw_pkg::STAMP_W'(in_data.timeout);
    req.tmo        = in_data.timeout;
    req.now        = in_data.now_time;
  end

  assign push = accept && !drop;
  assign pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= req;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/retw_mod.sv
// ---------------------------------------------------------------------------
// retw_mod
// Remainder of a 32-bit value by the wheel size through a reciprocal multiply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module retw_mod #(
  parameter int DIVISOR = 8192
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [retw_pkg::STAMP_W-1:0] dividend,
  output logic                              done,
  output logic [$clog2(DIVISOR)-1:0]        rem
);

  localparam int RW = $clog2(DIVISOR);
  localparam int XW = retw_pkg::STAMP_W;
  // ceil(2^(XW+RW) / DIVISOR) yields the exact quotient of any XW-bit value
  localparam logic [63:0] MAGIC64 =
    ((64'd1 << (XW + RW)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [15:0]   M_LO = MAGIC64[15:0];
  localparam logic [16:0]   M_HI = MAGIC64[32:16];
  localparam logic [RW-1:0] D_LO = RW'(DIVISOR);

  logic          s1_r, s2_r, s3_r, done_r;
  logic [XW-1:0] x_r;
  logic [47:0]   plo_r;
  logic [48:0]   phi_r;
  logic [64:0]   prod;
  logic [XW-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;

  assign done = done_r;
  assign rem  = rem_r;

  always_comb begin
    prod    = {phi_r, 16'h0000} + 65'(plo_r);
    q_nxt   = XW'(prod >> (XW + RW));
    // remainder is below the divisor, so the low bits suffice
    rem_nxt = x_r[RW-1:0] - q_r[RW-1:0] * D_LO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
    end
    if (s1_r) begin
      plo_r <= 48'(x_r) * 48'(M_LO);
      phi_r <= 49'(x_r) * 49'(M_HI);
    end
    if (s2_r) begin
      q_r <= q_nxt;
    end
    if (s3_r) begin
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/retw_back.sv
// ---------------------------------------------------------------------------
// retw_back
// Executes queued requests on the connection table and scans ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module retw_back #(
  parameter int WHEEL_SLOTS = 8192,
  parameter int MAX_CONNS   = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire retw_pkg::req_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output retw_pkg::out_t      out_data
);

  localparam int IW  = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
  localparam int CNW = $clog2(MAX_CONNS + 1);
  localparam int RW  = $clog2(WHEEL_SLOTS);
  localparam int SW  = $clog2(WHEEL_SLOTS + 1);
  localparam int KW  = SW + 1;
  localparam logic [SW-1:0] IDLE_SLOT = SW'(WHEEL_SLOTS);
  localparam logic [KW-1:0] SLOTS_K   = KW'(WHEEL_SLOTS);
  localparam int SHW = retw_pkg::STAMP_W;
  localparam int EW  = retw_pkg::EMIT_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_REF  = 7'b0000010,
    S_RMOD = 7'b0000100,
    S_RUPD = 7'b0001000,
    S_TMOD = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // connection table
  logic [SW-1:0]               slot_mem  [MAX_CONNS];
  logic [retw_pkg::TMO_W-1:0]  tmo_mem   [MAX_CONNS];
  logic [retw_pkg::RANK_W-1:0] rank_mem  [MAX_CONNS];
  logic [SW-1:0]               rd_slot_r;
  logic [retw_pkg::TMO_W-1:0]  rd_tmo_r;
  logic [retw_pkg::RANK_W-1:0] rd_rank_r;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic                        we;
  logic [IW-1:0]               waddr;
  logic [SW-1:0]               wslot;
  logic [retw_pkg::TMO_W-1:0]  wtmo;
  logic [retw_pkg::RANK_W-1:0] wrank;

  logic [MAX_CONNS-1:0]        present_r, present_nxt;
  logic [MAX_CONNS-1:0]        emitted_r, emitted_nxt;
  logic [retw_pkg::RANK_W-1:0] counter_r, counter_nxt;
  logic [SHW-1:0]              last_tick_r, last_tick_nxt;
  retw_pkg::req_t              req_r;
  logic [SW-1:0]               new_slot_r, new_slot_nxt;

  // tick scan
  logic [RW-1:0]               start_r, start_nxt;
  logic [SHW-1:0]              gap_r, gap_nxt;
  logic                        all_r, all_nxt;
  logic                        counting_r, counting_nxt;
  logic [CNW-1:0]              scan_cnt_r, scan_cnt_nxt;
  logic                        eval_v_r, eval_v_nxt;
  logic [IW-1:0]               eval_idx_r, eval_idx_nxt;
  logic [CNW-1:0]              cand_cnt_r, cand_cnt_nxt;
  logic [EW-1:0]               total_r, total_nxt;
  logic [EW-1:0]               nemit_r, nemit_nxt;
  logic                        found_r, found_nxt;
  logic [KW-1:0]               best_k_r, best_k_nxt;
  logic [retw_pkg::RANK_W-1:0] best_rank_r, best_rank_nxt;
  logic [IW-1:0]               best_idx_r, best_idx_nxt;
  logic [retw_pkg::TMO_W-1:0]  best_tmo_r, best_tmo_nxt;

  logic                        out_valid_r, out_valid_nxt;
  retw_pkg::out_t              out_data_r, out_data_nxt;

  logic                        mod_start, mod_done;
  logic [SHW-1:0]              mod_in;
  logic [RW-1:0]               mod_rem;

  logic [KW-1:0]               k;
  logic                        cand, better, emit_go, emit_last;
  logic [SHW-1:0]              t_max;

  retw_mod #(.DIVISOR(WHEEL_SLOTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_in),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  assign t_max = (req_r.sum < last_tick_r) ? last_tick_r : req_r.sum;

  // position of a stored slot along the scan, and its eligibility;
  // a full-wheel scan runs from slot 0
  always_comb begin
    if (all_r) begin
      k = KW'(rd_slot_r);
    end else if ({1'b0, rd_slot_r} >= KW'(start_r)) begin
      k = KW'(rd_slot_r) - KW'(start_r);
    end else begin
      k = KW'(rd_slot_r) + SLOTS_K - KW'(start_r);
    end
    cand = present_r[eval_idx_r] && (rd_slot_r < IDLE_SLOT) && !emitted_r[eval_idx_r]
           && (all_r || (SHW'(k) < gap_r));
    better = !found_r || ({k, rd_rank_r} < {best_k_r, best_rank_r});
  end

  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = (nemit_r + EW'(1)) == total_r;

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    emitted_nxt   = emitted_r;
    counter_nxt   = counter_r;
    last_tick_nxt = last_tick_r;
    new_slot_nxt  = new_slot_r;
    start_nxt     = start_r;
    gap_nxt       = gap_r;
    all_nxt       = all_r;
    counting_nxt  = counting_r;
    scan_cnt_nxt  = scan_cnt_r;
    eval_v_nxt    = 1'b0;
    eval_idx_nxt  = eval_idx_r;
    cand_cnt_nxt  = cand_cnt_r;
    total_nxt     = total_r;
    nemit_nxt     = nemit_r;
    found_nxt     = found_r;
    best_k_nxt    = best_k_r;
    best_rank_nxt = best_rank_r;
    best_idx_nxt  = best_idx_r;
    best_tmo_nxt  = best_tmo_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = scan_cnt_r[IW-1:0];
    we            = 1'b0;
    waddr         = IW'(req_r.conn);
    wslot         = IDLE_SLOT;
    wtmo          = req_r.tmo;
    wrank         = counter_r;
    mod_start     = 1'b0;
    mod_in        = last_tick_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_data.cmd)
            retw_pkg::CMD_ADD: begin
              if (!present_r[IW'(q_data.conn)]) begin
                present_nxt[IW'(q_data.conn)] = 1'b1;
                we          = 1'b1;
                waddr       = IW'(q_data.conn);
                wslot       = IDLE_SLOT;
                wtmo        = '0;
                wrank       = counter_r;
                counter_nxt = counter_r + 1'b1;
              end
            end
            retw_pkg::CMD_REMOVE: begin
              present_nxt[IW'(q_data.conn)] = 1'b0;
            end
            retw_pkg::CMD_REFRESH: begin
              if (present_r[IW'(q_data.conn)]) begin
                rd_en     = 1'b1;
                rd_addr   = IW'(q_data.conn);
                state_nxt = S_REF;
              end
            end
            retw_pkg::CMD_TICK: begin
              mod_start = 1'b1;
              mod_in    = last_tick_r;
              state_nxt = S_TMOD;
            end
            default: ;
          endcase
        end
      end
      S_REF: begin
        if (req_r.stamp_zero) begin
          new_slot_nxt = IDLE_SLOT;
          state_nxt    = S_RUPD;
        end else begin
          mod_start = 1'b1;
          mod_in    = t_max;
          state_nxt = S_RMOD;
        end
      end
      S_RMOD: begin
        if (mod_done) begin
          new_slot_nxt = SW'(mod_rem);
          state_nxt    = S_RUPD;
        end
      end
      S_RUPD: begin
        we    = 1'b1;
        wslot = new_slot_r;
        wtmo  = req_r.tmo;
        if (new_slot_r != rd_slot_r) begin
          wrank       = counter_r;
          counter_nxt = counter_r + 1'b1;
        end else begin
          wrank = rd_rank_r;
        end
        state_nxt = S_IDLE;
      end
      S_TMOD: begin
        if (mod_done) begin
          start_nxt    = mod_rem;
          gap_nxt      = req_r.now - last_tick_r;
          all_nxt      = {1'b0, req_r.now - last_tick_r} >= (SHW+1)'(WHEEL_SLOTS);
          counting_nxt = 1'b1;
          scan_cnt_nxt = '0;
          cand_cnt_nxt = '0;
          emitted_nxt  = '0;
          nemit_nxt    = '0;
          found_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (int'(scan_cnt_r) < MAX_CONNS) begin
          rd_en        = 1'b1;
          rd_addr      = scan_cnt_r[IW-1:0];
          eval_v_nxt   = 1'b1;
          eval_idx_nxt = scan_cnt_r[IW-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (eval_v_r && cand) begin
          if (counting_r) begin
            cand_cnt_nxt = cand_cnt_r + 1'b1;
          end else if (better) begin
            found_nxt     = 1'b1;
            best_k_nxt    = k;
            best_rank_nxt = rd_rank_r;
            best_idx_nxt  = eval_idx_r;
            best_tmo_nxt  = rd_tmo_r;
          end
        end
        // pass complete
        if (int'(scan_cnt_r) == MAX_CONNS && !eval_v_r) begin
          if (counting_r) begin
            total_nxt = (int'(cand_cnt_r) > retw_pkg::RESULT_CAP) ?
                        EW'(retw_pkg::RESULT_CAP) : EW'(cand_cnt_r);
            if (cand_cnt_r == '0) begin
              last_tick_nxt = req_r.now;
              state_nxt     = S_IDLE;
            end else begin
              counting_nxt = 1'b0;
              scan_cnt_nxt = '0;
              found_nxt    = 1'b0;
            end
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.due_conn    = retw_pkg::CONN_W'(best_idx_r);
          out_data_nxt.due_timeout = best_tmo_r;
          out_data_nxt.last        = emit_last;
          emitted_nxt[best_idx_r]  = 1'b1;
          nemit_nxt                = nemit_r + EW'(1);
          if (emit_last) begin
            last_tick_nxt = req_r.now;
            state_nxt     = S_IDLE;
          end else begin
            scan_cnt_nxt = '0;
            found_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      counter_r   <= '0;
      last_tick_r <= '0;
      out_valid_r <= 1'b0;
      eval_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      counter_r   <= counter_nxt;
      last_tick_r <= last_tick_nxt;
      out_valid_r <= out_valid_nxt;
      eval_v_r    <= eval_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_data;
    end
    emitted_r   <= emitted_nxt;
    new_slot_r  <= new_slot_nxt;
    start_r     <= start_nxt;
    gap_r       <= gap_nxt;
    all_r       <= all_nxt;
    counting_r  <= counting_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    eval_idx_r  <= eval_idx_nxt;
    cand_cnt_r  <= cand_cnt_nxt;
    total_r     <= total_nxt;
    nemit_r     <= nemit_nxt;
    found_r     <= found_nxt;
    best_k_r    <= best_k_nxt;
    best_rank_r <= best_rank_nxt;
    best_idx_r  <= best_idx_nxt;
    best_tmo_r  <= best_tmo_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wslot;
      tmo_mem[waddr]  <= wtmo;
      rank_mem[waddr] <= wrank;
    end
    if (rd_en) begin
      rd_slot_r <= slot_mem[rd_addr];
      rd_tmo_r  <= tmo_mem[rd_addr];
      rd_rank_r <= rank_mem[rd_addr];
    end
  end

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> found_r)
    else $error("emit without a selected connection");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_RMOD || state_r == S_TMOD))
    else $error("remainder finished outside a wait state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && emit_last) |=> (state_r == S_IDLE && out_valid_r && out_data_r.last))
    else $error("final result did not close the tick");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (nemit_r < total_r))
    else $error("more results than counted");

endmodule
`default_nettype wire

>>> rtl/core/retransmit_timer_wheel.sv
// ---------------------------------------------------------------------------
// retransmit_timer_wheel
// Hashed timing wheel of retransmission timeouts over a connection table.
// ---------------------------------------------------------------------------
//   channel  direction  payload           handshake
//   in_      input      retw_pkg::in_t    in_valid / in_stall
//   out_     output     retw_pkg::out_t   out_valid / out_stall
//
// Add and remove complete in S_IDLE of the back end; refresh passes through
// S_REF, S_RMOD (the reciprocal remainder unit) and S_RUPD, skipping S_RMOD
// with a zero stamp. A tick runs the remainder unit in S_TMOD, then makes
// (R + 1) passes over the table memory, each after the first followed by one
// result in S_EMIT, R being the number of due results (at most 32); out_stall
// can hold each result. Reset is synchronous; no clearing pass. A two-entry
// request queue takes input while the back end works or out_stall holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module retransmit_timer_wheel #(
  parameter int WHEEL_SLOTS = 8192,
  parameter int MAX_CONNS   = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire retw_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output retw_pkg::out_t      out_data
);

  logic           q_valid, q_pop;
  retw_pkg::req_t q_data;

  retw_front #(.MAX_CONNS(MAX_CONNS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  retw_back #(.WHEEL_SLOTS(WHEEL_SLOTS), .MAX_CONNS(MAX_CONNS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> sim/retransmit_timer_wheel_tb.sv
// ---------------------------------------------------------------------------
// retransmit_timer_wheel_tb
// Drives add, remove, refresh and tick requests into the timer wheel and
// checks every due-connection result against an in-bench wheel predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class wheel_scoreboard;
  localparam int SLOTS = 8192;
  localparam int CONNS = 32;
  bit             present [CONNS];
  logic [13:0]    slot_of [CONNS];
  logic [31:0]    stamp_of [CONNS];
  logic [12:0]    tmo_of [CONNS];
  logic [47:0]    rank_of [CONNS];
  logic [47:0]    rank_ctr;
  logic [31:0]    last_tick;
  retw_pkg::out_t due_q[$];
  int             errors;

  function new();
    for (int i = 0; i < CONNS; i++) begin
      present[i] = 0; slot_of[i] = 0; stamp_of[i] = 0; tmo_of[i] = 0; rank_of[i] = 0;
    end
    rank_ctr = 0; last_tick = 0; errors = 0;
  endfunction

  function void take_rank(int c);
    rank_of[c] = rank_ctr;
    rank_ctr = rank_ctr + 48'd1;
  endfunction

  function void note_request(retw_pkg::in_t r);
    int c;
    logic [31:0] gap, start, k, t;
    logic [13:0] s;
    int idx[$];
    logic [31:0] key[$];
    int j;
    bit all;
    retw_pkg::out_t o;
    c = r.conn_id;
    if (r.command == retw_pkg::CMD_TICK) begin
      gap = r.now_time - last_tick;
      all = gap >= SLOTS;
      start = last_tick % SLOTS;
      for (int i = 0; i < CONNS; i++) begin
        if (!present[i] || slot_of[i] >= SLOTS) continue;
        if (all) k = 32'(slot_of[i]);
        else begin
          k = (slot_of[i] >= start) ? slot_of[i] - start : slot_of[i] + SLOTS - start;
          if (k >= gap) continue;
        end
        j = idx.size();
        while (j > 0 && (key[j-1] > k || (key[j-1] == k && rank_of[idx[j-1]] > rank_of[i])))
          j--;
        idx.insert(j, i);
        key.insert(j, k);
      end
      last_tick = r.now_time;
      foreach (idx[n]) begin
        o.due_conn = 5'(idx[n]);
        o.due_timeout = tmo_of[idx[n]];
        o.last = (n == idx.size() - 1);
        due_q = {due_q, o};
      end
    end else if (r.command == retw_pkg::CMD_ADD) begin
      if (!present[c]) begin
        present[c] = 1; slot_of[c] = 14'(SLOTS); stamp_of[c] = 0; tmo_of[c] = 0;
        take_rank(c);
      end
    end else if (r.command == retw_pkg::CMD_REMOVE) begin
      present[c] = 0;
    end else if (present[c] && r.timeout != 0) begin
      stamp_of[c] = r.stamp;
      tmo_of[c] = r.timeout;
      if (r.stamp == 0) s = 14'(SLOTS);
      else begin
        t = r.stamp + 32'(r.timeout);
        if (t < last_tick) t = last_tick;
        s = 14'(t % SLOTS);
      end
      if (s != slot_of[c]) begin
        slot_of[c] = s;
        take_rank(c);
      end
    end
  endfunction

  function void check_result(retw_pkg::out_t got);
    retw_pkg::out_t want;
    if (due_q.size() == 0) begin
      $error("unexpected result conn=%0d", got.due_conn);
      errors++;
      return;
    end
    want = due_q.pop_front();
    if (got.due_conn !== want.due_conn) begin
      $error("due_conn expected %0d actual %0d", want.due_conn, got.due_conn); errors++;
    end
    if (got.due_timeout !== want.due_timeout) begin
      $error("due_timeout expected %0d actual %0d", want.due_timeout, got.due_timeout);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last expected %0d actual %0d", want.last, got.last); errors++;
    end
  endfunction
endclass

module retransmit_timer_wheel_tb;
  localparam int WATCH_LIMIT = 20000;

  logic           clk = 0;
  logic           rst_n = 0;
  logic           in_valid = 0;
  logic           in_stall;
  retw_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 0;
  retw_pkg::out_t out_data;

  wheel_scoreboard board = new();
  bit   stim_done = 0;
  bit   hold_out = 0;
  int   idle_cycles = 0;
  logic [31:0] clock_now = 0;

  always #4 clk = ~clk;

  retransmit_timer_wheel dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_request(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("retransmit_timer_wheel_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall per result, plus a forced long hold
  initial begin : receiver
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        hold_out = 0;
      end
      w = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_request(retw_pkg::in_t r, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (w != 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (board.due_q.size() != 0) @(posedge clk);
  endtask

  function automatic retw_pkg::in_t make_req(retw_pkg::cmd_t c, int id, logic [31:0] st,
                                             logic [12:0] tm, logic [31:0] nw);
    retw_pkg::in_t r;
    r.command = c; r.conn_id = 5'(id); r.stamp = st; r.timeout = tm; r.now_time = nw;
    return r;
  endfunction

  task automatic random_request(bit gaps);
    int pick;
    retw_pkg::in_t r;
    pick = $urandom_range(0, 9);
    r.stamp = $urandom;
    r.timeout = 13'($urandom_range(1, 8191));
    r.conn_id = 5'($urandom_range(0, 31));
    r.now_time = $urandom;
    if (pick < 2) r.command = retw_pkg::CMD_ADD;
    else if (pick < 3) r.command = retw_pkg::CMD_REMOVE;
    else if (pick < 7) begin
      r.command = retw_pkg::CMD_REFRESH;
      // mostly near the present time so ticks catch them
      case ($urandom_range(0, 7))
        0: r.stamp = 0;
        1: r.timeout = 0;
        2: ;
        default: r.stamp = clock_now + $urandom_range(0, 200);
      endcase
      if ($urandom_range(0, 9) == 0) r.timeout = 13'h1FFF;
    end else begin
      r.command = retw_pkg::CMD_TICK;
      case ($urandom_range(0, 5))
        0: r.now_time = clock_now;
        1: ;
        2: r.now_time = clock_now + 8192 + $urandom_range(0, 9);
        default: r.now_time = clock_now + $urandom_range(1, 9000);
      endcase
      clock_now = r.now_time;
    end
    send_request(r, gaps);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes and each special case
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, 0), 0);
    send_request(make_req(retw_pkg::CMD_ADD, 0, 0, 1, 0), 0);
    send_request(make_req(retw_pkg::CMD_ADD, 31, 0, 1, 0), 0);
    send_request(make_req(retw_pkg::CMD_ADD, 0, 0, 1, 0), 0);         // already present
    send_request(make_req(retw_pkg::CMD_REFRESH, 5, 10, 5, 0), 0);    // absent
    send_request(make_req(retw_pkg::CMD_REMOVE, 6, 0, 1, 0), 0);      // absent
    send_request(make_req(retw_pkg::CMD_REFRESH, 0, 10, 0, 0), 0);    // zero timeout
    send_request(make_req(retw_pkg::CMD_REFRESH, 0, 10, 20, 0), 0);
    send_request(make_req(retw_pkg::CMD_REFRESH, 31, 29, 1, 0), 0);
    send_request(make_req(retw_pkg::CMD_REFRESH, 0, 11, 19, 0), 0);   // same slot
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, 100), 0);
    send_request(make_req(retw_pkg::CMD_REFRESH, 31, 32'hFFFF_FFFF, 13'h1FFF, 0), 0);
    send_request(make_req(retw_pkg::CMD_REFRESH, 0, 0, 7, 0), 0);     // idle stamp
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, 32'hFFFF_FFFF), 0);
    send_request(make_req(retw_pkg::CMD_REFRESH, 0, 5, 1, 0), 0);     // clamp to last tick
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, 32'h0000_2000), 0);
    send_request(make_req(retw_pkg::CMD_REMOVE, 31, 0, 1, 0), 0);
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, 32'h0000_4000), 0);
    clock_now = 32'h4000;
    for (int i = 0; i < 32; i++) send_request(make_req(retw_pkg::CMD_ADD, i, 0, 1, 0), 1);
    for (int i = 0; i < 32; i++)
      send_request(make_req(retw_pkg::CMD_REFRESH, i, clock_now + 3,
                            13'($urandom_range(1, 4)), 0), 1);
    clock_now = clock_now + 10;
    send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, clock_now), 0);  // up to 32 results
    drain_results();
    // long receiver hold while the sender keeps offering
    hold_out = 1;
    for (int i = 0; i < 20; i++) random_request(0);
    drain_results();
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(0, 4) == 0) random_request(0);
      else random_request(1);
      if (n % 40 == 39) begin
        for (int i = 0; i < 32; i++)
          send_request(make_req(retw_pkg::CMD_REFRESH, i, clock_now + 1,
                                13'($urandom_range(1, 3)), 0), 0);
        clock_now = clock_now + 5;
        send_request(make_req(retw_pkg::CMD_TICK, 0, 0, 1, clock_now), 1);
      end
    end
    drain_results();
    repeat (3000) @(posedge clk);
    if (board.errors == 0 && board.due_q.size() == 0)
      $display("retransmit_timer_wheel_tb: done, clean");
    else
      $display("retransmit_timer_wheel_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

>>> retransmit_timer_wheel.f
rtl/core/retw_pkg.sv
rtl/core/retw_front.sv
rtl/core/retw_mod.sv
rtl/core/retw_back.sv
rtl/core/retransmit_timer_wheel.sv
sim/retransmit_timer_wheel_tb.sv
